/* sv/pfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Packet ring FIFO package
// Shared widths, request codes and register indexes of the packet ring FIFO.
// ----------------------------------------------------------------------------
package pfr_pkg;

  // Default ring size in bytes.
  localparam int RING_DEPTH_DEF = 512;

  // Every stored packet is preceded by a header of this many bytes.
  localparam int HDR_BYTES = 4;

  // Field widths.
  localparam int MODE_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 8;
  localparam int RSSI_W     = 16;
  localparam int AVAIL_W    = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Request codes on in_mode.
  typedef enum logic [MODE_W-1:0] {
    MODE_RX    = 3'd0,
    MODE_NEXT  = 3'd1,
    MODE_READ  = 3'd2,
    MODE_PEEK  = 3'd3,
    MODE_PURGE = 3'd4
  } mode_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR = 1'd1;

endpackage
`default_nettype wire

/* sv/packet_ring_fifo_with_headers_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Packet ring FIFO with headers
// Byte ring of received packets, each stored behind a four-byte header.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows on
// the out_ ports for one cycle with out_valid high and cannot be held off.
// Packet bytes and headers live in one single-port byte memory, which sets
// the timing: a received byte or a purge is answered from the idle state,
// read and peek add a memory read when a byte is left in the current packet,
// a received byte that completes a kept packet adds four header writes, and
// next packet adds four header reads plus the read latency when a packet is
// waiting but is answered from the idle state when the ring is empty. A result
// appears the cycle after the request completes, while the next request may
// already be accepted. The ring memory needs no clearing after reset.
module packet_ring_fifo_with_headers_top #(
  parameter int RING_DEPTH = pfr_pkg::RING_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [pfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pfr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [pfr_pkg::MODE_W-1:0]       in_mode,
  input  wire logic [pfr_pkg::BYTE_W-1:0]       in_data_byte,
  input  wire logic                             in_rx_first,
  input  wire logic [pfr_pkg::LEN_W-1:0]        in_rx_length,
  input  wire logic [pfr_pkg::RSSI_W-1:0]       in_rx_rssi,
  output logic                                  out_valid,
  output logic      [pfr_pkg::BYTE_W-1:0]       out_data_out,
  output logic                                  out_data_valid,
  output logic      [pfr_pkg::RSSI_W-1:0]       out_packet_rssi,
  output logic                                  out_packet_broadcast,
  output logic      [pfr_pkg::AVAIL_W-1:0]      out_bytes_available,
  output logic                                  out_packet_dropped
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  logic                       filter_r;
  logic [pfr_pkg::BYTE_W-1:0] node_addr_r;

  logic                       mem_we;
  logic [PTR_W-1:0]           mem_addr;
  logic [pfr_pkg::BYTE_W-1:0] mem_wdata;
  logic [pfr_pkg::BYTE_W-1:0] mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r    <= 1'b0;
      node_addr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfr_pkg::CFG_FILTER:    filter_r    <= cfg_wdata[0];
        pfr_pkg::CFG_NODE_ADDR: node_addr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request sequencing and pointer state.
  pfr_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .PTR_W      (PTR_W)
  ) u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .filter_on            (filter_r),
    .node_addr            (node_addr_r),
    .start                (start),
    .busy                 (busy),
    .in_mode              (in_mode),
    .in_data_byte         (in_data_byte),
    .in_rx_first          (in_rx_first),
    .in_rx_length         (in_rx_length),
    .in_rx_rssi           (in_rx_rssi),
    .out_valid            (out_valid),
    .out_data_out         (out_data_out),
    .out_data_valid       (out_data_valid),
    .out_packet_rssi      (out_packet_rssi),
    .out_packet_broadcast (out_packet_broadcast),
    .out_bytes_available  (out_bytes_available),
    .out_packet_dropped   (out_packet_dropped),
    .mem_we               (mem_we),
    .mem_addr             (mem_addr),
    .mem_wdata            (mem_wdata),
    .mem_rdata            (mem_rdata)
  );

  // Packet byte ring.
  pfr_ring_mem #(
    .RING_DEPTH (RING_DEPTH),
    .PTR_W      (PTR_W)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

/* sv/pfr_ring_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Packet ring byte memory
// Single-port synchronous byte memory with registered read data.
// ----------------------------------------------------------------------------
module pfr_ring_mem #(
  parameter int RING_DEPTH = pfr_pkg::RING_DEPTH_DEF,
  parameter int PTR_W      = $clog2(RING_DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [PTR_W-1:0]          addr,
  input  wire logic [pfr_pkg::BYTE_W-1:0] wdata,
  output logic      [pfr_pkg::BYTE_W-1:0] rdata
);

  logic [pfr_pkg::BYTE_W-1:0] mem [RING_DEPTH];
  logic [pfr_pkg::BYTE_W-1:0] rdata_r;

  // One access per cycle: either a write or a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* sv/pfr_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Packet ring controller
// Pointer state, request sequencing and header access for the packet ring.
// ----------------------------------------------------------------------------
module pfr_ctrl #(
  parameter int RING_DEPTH = pfr_pkg::RING_DEPTH_DEF,
  parameter int PTR_W      = $clog2(RING_DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Configuration.
  input  wire logic                         filter_on,
  input  wire logic [pfr_pkg::BYTE_W-1:0]   node_addr,
  // Request channel.
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [pfr_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [pfr_pkg::BYTE_W-1:0]   in_data_byte,
  input  wire logic                         in_rx_first,
  input  wire logic [pfr_pkg::LEN_W-1:0]    in_rx_length,
  input  wire logic [pfr_pkg::RSSI_W-1:0]   in_rx_rssi,
  // Result channel.
  output logic                              out_valid,
  output logic      [pfr_pkg::BYTE_W-1:0]   out_data_out,
  output logic                              out_data_valid,
  output logic      [pfr_pkg::RSSI_W-1:0]   out_packet_rssi,
  output logic                              out_packet_broadcast,
  output logic      [pfr_pkg::AVAIL_W-1:0]  out_bytes_available,
  output logic                              out_packet_dropped,
  // Ring memory port.
  output logic                              mem_we,
  output logic      [PTR_W-1:0]             mem_addr,
  output logic      [pfr_pkg::BYTE_W-1:0]   mem_wdata,
  input  wire logic [pfr_pkg::BYTE_W-1:0]   mem_rdata
);

  localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W+1)'(RING_DEPTH);
  localparam logic [PTR_W-1:0] DEPTH_M1  = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W-1:0] HDR_P     = PTR_W'(pfr_pkg::HDR_BYTES);
  localparam logic [2:0]       HDR_LAST  = 3'(pfr_pkg::HDR_BYTES - 1);
  localparam logic [2:0]       POP_LAST  = 3'(pfr_pkg::HDR_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HDR  = 4'b0010,
    ST_POP  = 4'b0100,
    ST_RD   = 4'b1000
  } ctrl_state_t;

  // Ring index arithmetic; both operands are below the depth.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W-1:0] n);
    logic [PTR_W:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] from,
                                                 input logic [PTR_W-1:0] to);
    logic [PTR_W:0] s;
    s = {1'b0, to} + DEPTH_X - {1'b0, from};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[PTR_W-1:0];
  endfunction

  ctrl_state_t state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;

  logic [PTR_W-1:0] release_r, release_nxt;
  logic [PTR_W-1:0] commit_r, commit_nxt;
  logic [PTR_W-1:0] read_r, read_nxt;
  logic [PTR_W-1:0] end_r, end_nxt;
  logic [PTR_W-1:0] fill_r, fill_nxt;
  logic             pkt_cur_r, pkt_cur_nxt;
  logic [pfr_pkg::RSSI_W-1:0] cur_rssi_r, cur_rssi_nxt;
  logic             cur_bc_r, cur_bc_nxt;
  logic [pfr_pkg::LEN_W-1:0]  left_r, left_nxt;
  logic             acc_r, acc_nxt;

  // Incoming packet header and popped header bytes.
  logic [pfr_pkg::LEN_W-1:0]  inc_len_r, inc_len_nxt;
  logic [pfr_pkg::RSSI_W-1:0] inc_rssi_r, inc_rssi_nxt;
  logic                       inc_bc_r, inc_bc_nxt;
  logic [PTR_W-1:0]           hdr_base_r, hdr_base_nxt;
  logic [pfr_pkg::BYTE_W-1:0] plen_r, plen_nxt;
  logic [pfr_pkg::BYTE_W-1:0] rssi_lo_r, rssi_lo_nxt;
  logic [pfr_pkg::BYTE_W-1:0] rssi_hi_r, rssi_hi_nxt;

  // Result register.
  logic                        out_valid_r, emit;
  logic [pfr_pkg::BYTE_W-1:0]  o_data_r, o_data_nxt;
  logic                        o_dv_r, o_dv_nxt;
  logic [pfr_pkg::RSSI_W-1:0]  o_rssi_r;
  logic                        o_bc_r;
  logic [pfr_pkg::AVAIL_W-1:0] o_avail_r, o_avail_nxt;
  logic                        o_drop_r, o_drop_nxt;

  logic accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);

  // Request sequencing and pointer updates.
  always_comb begin
    logic                       strip;
    logic [PTR_W-1:0]           free_sp;
    logic [pfr_pkg::AVAIL_W-1:0] need;
    logic [PTR_W-1:0]           fill_t;
    logic [pfr_pkg::LEN_W-1:0]  left_t;
    logic                       acc_t;
    logic [PTR_W-1:0]           rel_t;
    logic [PTR_W-1:0]           rp_t;
    logic [PTR_W+8:0]           avail_x;

    strip        = 1'b0;
    free_sp      = '0;
    need         = '0;
    fill_t       = fill_r;
    left_t       = left_r;
    acc_t        = acc_r;
    rel_t        = release_r;
    rp_t         = read_r;

    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    release_nxt  = release_r;
    commit_nxt   = commit_r;
    read_nxt     = read_r;
    end_nxt      = end_r;
    fill_nxt     = fill_r;
    pkt_cur_nxt  = pkt_cur_r;
    cur_rssi_nxt = cur_rssi_r;
    cur_bc_nxt   = cur_bc_r;
    left_nxt     = left_r;
    acc_nxt      = acc_r;
    inc_len_nxt  = inc_len_r;
    inc_rssi_nxt = inc_rssi_r;
    inc_bc_nxt   = inc_bc_r;
    hdr_base_nxt = hdr_base_r;
    plen_nxt     = plen_r;
    rssi_lo_nxt  = rssi_lo_r;
    rssi_hi_nxt  = rssi_hi_r;

    emit         = 1'b0;
    o_data_nxt   = '0;
    o_dv_nxt     = 1'b0;
    o_drop_nxt   = 1'b0;

    mem_we       = 1'b0;
    mem_addr     = read_r;
    mem_wdata    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (pfr_pkg::mode_t'(in_mode))
            pfr_pkg::MODE_RX: begin
              // A first byte restarts reception and decides on space.
              if (in_rx_first) begin
                acc_t  = 1'b0;
                left_t = '0;
                if (in_rx_length == '0) begin
                  o_drop_nxt = 1'b1;
                end else begin
                  free_sp = ring_dist(commit_r, release_r);
                  free_sp = (free_sp == '0) ? DEPTH_M1 : free_sp - 1'b1;
                  need    = pfr_pkg::AVAIL_W'(pfr_pkg::HDR_BYTES) +
                            {1'b0, in_rx_length} -
                            pfr_pkg::AVAIL_W'(filter_on);
                  left_t  = in_rx_length;
                  if ({9'b0, free_sp} >= {PTR_W'(0), need}) begin
                    acc_t        = 1'b1;
                    inc_len_nxt  = in_rx_length - pfr_pkg::LEN_W'(filter_on);
                    inc_rssi_nxt = in_rx_rssi;
                    inc_bc_nxt   = filter_on && (in_data_byte != node_addr);
                    fill_t       = ring_add(commit_r, HDR_P);
                    strip        = filter_on;
                  end
                end
              end
              // Store or drop the byte of a packet in progress.
              if (left_t != '0) begin
                if (acc_t) begin
                  o_dv_nxt = 1'b1;
                  if (!strip) begin
                    mem_we    = 1'b1;
                    mem_addr  = fill_t;
                    mem_wdata = in_data_byte;
                    fill_t    = ring_add(fill_t, PTR_W'(1));
                  end
                end else begin
                  o_drop_nxt = 1'b1;
                end
                left_t = left_t - 1'b1;
              end
              fill_nxt = fill_t;
              left_nxt = left_t;
              acc_nxt  = acc_t;
              // Last byte of a kept packet: write its header, then publish.
              if (left_t == '0 && acc_t) begin
                hdr_base_nxt = commit_r;
                commit_nxt   = fill_t;
                acc_nxt      = 1'b0;
                state_nxt    = ST_HDR;
                cnt_nxt      = '0;
              end else begin
                emit = 1'b1;
              end
            end
            pfr_pkg::MODE_NEXT: begin
              // Release the current packet, then pop the next header if any.
              if (pkt_cur_r) begin
                rel_t    = end_r;
                read_nxt = end_r;
              end
              release_nxt  = rel_t;
              pkt_cur_nxt  = 1'b0;
              cur_rssi_nxt = '0;
              cur_bc_nxt   = 1'b0;
              if (rel_t != commit_r) begin
                state_nxt = ST_POP;
                cnt_nxt   = '0;
              end else begin
                emit = 1'b1;
              end
            end
            pfr_pkg::MODE_READ, pfr_pkg::MODE_PEEK: begin
              if (read_r != end_r) begin
                mem_addr  = read_r;
                state_nxt = ST_RD;
                if (in_mode == pfr_pkg::MODE_READ) begin
                  read_nxt = ring_add(read_r, PTR_W'(1));
                end
              end else begin
                emit = 1'b1;
              end
            end
            pfr_pkg::MODE_PURGE: begin
              release_nxt  = commit_r;
              read_nxt     = commit_r;
              end_nxt      = commit_r;
              pkt_cur_nxt  = 1'b0;
              cur_rssi_nxt = '0;
              cur_bc_nxt   = 1'b0;
              emit         = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_HDR: begin
        // Header bytes: length, signal strength low and high, broadcast.
        mem_we   = 1'b1;
        mem_addr = ring_add(hdr_base_r, PTR_W'(cnt_r));
        case (cnt_r)
          3'd0:    mem_wdata = inc_len_r;
          3'd1:    mem_wdata = inc_rssi_r[7:0];
          3'd2:    mem_wdata = inc_rssi_r[15:8];
          default: mem_wdata = {7'b0, inc_bc_r};
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == HDR_LAST) begin
          state_nxt = ST_IDLE;
          o_dv_nxt  = 1'b1;
          emit      = 1'b1;
        end
      end
      ST_POP: begin
        // Header reads are issued one per cycle; the memory registers each read's data.
        if (cnt_r != POP_LAST) begin
          mem_addr = ring_add(release_r, PTR_W'(cnt_r));
        end
        case (cnt_r)
          3'd1:    plen_nxt    = mem_rdata;
          3'd2:    rssi_lo_nxt = mem_rdata;
          3'd3:    rssi_hi_nxt = mem_rdata;
          default: ;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == POP_LAST) begin
          rp_t         = ring_add(release_r, HDR_P);
          read_nxt     = rp_t;
          end_nxt      = ring_add(rp_t, PTR_W'(plen_r));
          cur_rssi_nxt = {rssi_hi_r, rssi_lo_r};
          cur_bc_nxt   = (mem_rdata != '0);
          pkt_cur_nxt  = 1'b1;
          o_data_nxt   = plen_r;
          o_dv_nxt     = 1'b1;
          emit         = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RD: begin
        o_data_nxt = mem_rdata;
        o_dv_nxt   = 1'b1;
        emit       = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Unread bytes of the current packet after this request.
    avail_x     = {9'b0, ring_dist(read_nxt, end_nxt)};
    o_avail_nxt = avail_x[pfr_pkg::AVAIL_W-1:0];
  end

  // Control state and pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      release_r   <= '0;
      commit_r    <= '0;
      read_r      <= '0;
      end_r       <= '0;
      fill_r      <= '0;
      pkt_cur_r   <= 1'b0;
      cur_rssi_r  <= '0;
      cur_bc_r    <= 1'b0;
      left_r      <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      release_r   <= release_nxt;
      commit_r    <= commit_nxt;
      read_r      <= read_nxt;
      end_r       <= end_nxt;
      fill_r      <= fill_nxt;
      pkt_cur_r   <= pkt_cur_nxt;
      cur_rssi_r  <= cur_rssi_nxt;
      cur_bc_r    <= cur_bc_nxt;
      left_r      <= left_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= emit;
    end
  end

  // Header staging and result payload.
  always_ff @(posedge clk) begin
    inc_len_r  <= inc_len_nxt;
    inc_rssi_r <= inc_rssi_nxt;
    inc_bc_r   <= inc_bc_nxt;
    hdr_base_r <= hdr_base_nxt;
    plen_r     <= plen_nxt;
    rssi_lo_r  <= rssi_lo_nxt;
    rssi_hi_r  <= rssi_hi_nxt;
    o_data_r   <= o_data_nxt;
    o_dv_r     <= o_dv_nxt;
    o_rssi_r   <= cur_rssi_nxt;
    o_bc_r     <= cur_bc_nxt;
    o_avail_r  <= o_avail_nxt;
    o_drop_r   <= o_drop_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_data_out         = o_data_r;
  assign out_data_valid       = o_dv_r;
  assign out_packet_rssi      = o_rssi_r;
  assign out_packet_broadcast = o_bc_r;
  assign out_bytes_available  = o_avail_r;
  assign out_packet_dropped   = o_drop_r;

endmodule
`default_nettype wire

/* verif/tb_packet_ring_fifo_with_headers_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet ring FIFO with headers testbench
// Drives receive, next-packet, read, peek and purge requests through the
// start/busy handshake and checks every result against a cycle-free model of
// the ring, its headers and its read-side pointers. The run opens with a
// directed part, then goes through random phases with different filter
// settings and sender idling.
// ----------------------------------------------------------------------------
module tb_packet_ring_fifo_with_headers_top;
  import pfr_pkg::*;

  localparam int DEPTH          = RING_DEPTH_DEF;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  // One request as presented on the in_ ports.
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [BYTE_W-1:0]        data_byte;
    logic                     rx_first;
    logic [LEN_W-1:0]         rx_length;
    logic signed [RSSI_W-1:0] rx_rssi;
  } ring_req_t;

  // One result, in the order of the out_ ports.
  typedef struct packed {
    logic [BYTE_W-1:0]        data_out;
    logic                     data_valid;
    logic signed [RSSI_W-1:0] packet_rssi;
    logic                     packet_broadcast;
    logic [AVAIL_W-1:0]       bytes_available;
    logic                     packet_dropped;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [MODE_W-1:0] in_mode = '0;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic in_rx_first = 1'b0;
  logic [LEN_W-1:0] in_rx_length = '0;
  logic [RSSI_W-1:0] in_rx_rssi = '0;
  logic out_valid;
  logic [BYTE_W-1:0] out_data_out;
  logic out_data_valid;
  logic [RSSI_W-1:0] out_packet_rssi;
  logic out_packet_broadcast;
  logic [AVAIL_W-1:0] out_bytes_available;
  logic out_packet_dropped;

  packet_ring_fifo_with_headers_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_data_byte        (in_data_byte),
    .in_rx_first         (in_rx_first),
    .in_rx_length        (in_rx_length),
    .in_rx_rssi          (in_rx_rssi),
    .out_valid           (out_valid),
    .out_data_out        (out_data_out),
    .out_data_valid      (out_data_valid),
    .out_packet_rssi     (out_packet_rssi),
    .out_packet_broadcast(out_packet_broadcast),
    .out_bytes_available (out_bytes_available),
    .out_packet_dropped  (out_packet_dropped)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven and results waiting to be seen.
  ring_req_t    pending_items[$];
  ring_result_t expected_results[$];

  int  sender_idle_pct = 0;
  bit  req_taken = 1'b0;
  int  quiet_cycles = 0;
  int  error_count = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_phases = 0;
  int  n_commits = 0;
  int  n_pops = 0;
  int  n_dropped = 0;

  // Mirror of the configuration registers.
  bit             filter_on_m = 1'b0;
  bit [BYTE_W-1:0] node_addr_m = '0;

  // Mirror of the ring and its pointers.
  bit [7:0]        ring_mem [DEPTH];
  int              rel_ptr = 0;
  int              cmt_ptr = 0;
  int              rd_ptr = 0;
  int              end_ptr = 0;
  int              fill_ptr = 0;
  bit              have_packet = 1'b0;
  bit [RSSI_W-1:0] cur_rssi = '0;
  bit              cur_bcast = 1'b0;
  int              rx_left = 0;
  bit              rx_kept = 1'b0;
  bit [LEN_W-1:0]  rx_len_hdr = '0;
  bit [RSSI_W-1:0] rx_rssi_hdr = '0;
  bit              rx_bcast_hdr = 1'b0;

  function automatic int ring_fwd(input int p, input int n);
    return (p + n) % DEPTH;
  endfunction

  function automatic int ring_gap(input int from, input int to);
    return (to + DEPTH - from) % DEPTH;
  endfunction

  // Apply one request to the mirror and return the result it must produce.
  function automatic ring_result_t predict_ring(input ring_req_t r);
    ring_result_t res;
    bit strip;
    int free_bytes;
    int need;
    int plen;
    res = '0;
    strip = 1'b0;
    case (r.mode)
      MODE_RX: begin
        // A first byte restarts reception and decides on space.
        if (r.rx_first) begin
          rx_kept = 1'b0;
          rx_left = 0;
          if (r.rx_length == 0) begin
            res.packet_dropped = 1'b1;
          end else begin
            free_bytes = ring_gap(cmt_ptr, rel_ptr);
            free_bytes = (free_bytes == 0) ? DEPTH - 1 : free_bytes - 1;
            need = HDR_BYTES + int'(r.rx_length) - int'(filter_on_m);
            rx_left = r.rx_length;
            if (free_bytes >= need) begin
              rx_kept = 1'b1;
              rx_len_hdr = r.rx_length - filter_on_m;
              rx_rssi_hdr = r.rx_rssi;
              rx_bcast_hdr = 1'b0;
              fill_ptr = ring_fwd(cmt_ptr, HDR_BYTES);
              if (filter_on_m) begin
                strip = 1'b1;
                if (r.data_byte != node_addr_m) rx_bcast_hdr = 1'b1;
              end
            end
          end
        end
        // Store or refuse the byte; the last one writes the header.
        if (rx_left != 0) begin
          if (rx_kept) begin
            res.data_valid = 1'b1;
            if (!strip) begin
              ring_mem[fill_ptr] = r.data_byte;
              fill_ptr = ring_fwd(fill_ptr, 1);
            end
          end else begin
            res.packet_dropped = 1'b1;
          end
          rx_left--;
          if (rx_left == 0 && rx_kept) begin
            ring_mem[cmt_ptr] = rx_len_hdr;
            ring_mem[ring_fwd(cmt_ptr, 1)] = rx_rssi_hdr[7:0];
            ring_mem[ring_fwd(cmt_ptr, 2)] = rx_rssi_hdr[15:8];
            ring_mem[ring_fwd(cmt_ptr, 3)] = {7'd0, rx_bcast_hdr};
            cmt_ptr = fill_ptr;
            rx_kept = 1'b0;
            n_commits++;
          end
        end
      end
      MODE_NEXT: begin
        // Release the current packet, then pop the next header if any.
        if (have_packet) begin
          rd_ptr = end_ptr;
          rel_ptr = end_ptr;
        end
        have_packet = 1'b0;
        cur_rssi = '0;
        cur_bcast = 1'b0;
        if (rel_ptr != cmt_ptr) begin
          plen = ring_mem[rel_ptr];
          cur_rssi = {ring_mem[ring_fwd(rel_ptr, 2)], ring_mem[ring_fwd(rel_ptr, 1)]};
          cur_bcast = (ring_mem[ring_fwd(rel_ptr, 3)] != 0);
          rd_ptr = ring_fwd(rel_ptr, HDR_BYTES);
          end_ptr = ring_fwd(rd_ptr, plen);
          have_packet = 1'b1;
          res.data_out = BYTE_W'(plen);
          res.data_valid = 1'b1;
          n_pops++;
        end
      end
      MODE_READ, MODE_PEEK: begin
        if (rd_ptr != end_ptr) begin
          res.data_out = ring_mem[rd_ptr];
          res.data_valid = 1'b1;
          if (r.mode == MODE_READ) rd_ptr = ring_fwd(rd_ptr, 1);
        end
      end
      MODE_PURGE: begin
        rel_ptr = cmt_ptr;
        rd_ptr = cmt_ptr;
        end_ptr = cmt_ptr;
        have_packet = 1'b0;
        cur_rssi = '0;
        cur_bcast = 1'b0;
      end
      default: begin
      end
    endcase
    res.packet_rssi = cur_rssi;
    res.packet_broadcast = cur_bcast;
    res.bytes_available = AVAIL_W'(ring_gap(rd_ptr, end_ptr));
    if (res.packet_dropped) n_dropped++;
    return res;
  endfunction

  // Driver: present the head of the queue, hold it until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        in_mode <= pending_items[0].mode;
        in_data_byte <= pending_items[0].data_byte;
        in_rx_first <= pending_items[0].rx_first;
        in_rx_length <= pending_items[0].rx_length;
        in_rx_rssi <= pending_items[0].rx_rssi;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results, take requests and keep the watchdog count.
  always @(posedge clk) begin
    ring_req_t    taken;
    ring_result_t want;
    ring_result_t got;
    req_taken = 1'b0;
    if (rst_n) begin
      got = {out_data_out, out_data_valid, out_packet_rssi, out_packet_broadcast,
             out_bytes_available, out_packet_dropped};
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("[%0t] result with nothing expected: dout=%02h dv=%0b", $realtime,
                     got.data_out, got.data_valid);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (got !== want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("[%0t] mismatch, expected dout=%02h dv=%0b rssi=%04h bc=%0b avail=%0d drop=%0b",
                       $realtime, want.data_out, want.data_valid, want.packet_rssi,
                       want.packet_broadcast, want.bytes_available, want.packet_dropped);
              $display("            actual   dout=%02h dv=%0b rssi=%04h bc=%0b avail=%0d drop=%0b",
                       got.data_out, got.data_valid, got.packet_rssi,
                       got.packet_broadcast, got.bytes_available, got.packet_dropped);
            end
          end
        end
      end
      if (start && !busy) begin
        req_taken = 1'b1;
        taken = pending_items.pop_front();
        expected_results.push_back(predict_ring(taken));
        n_accepted++;
      end
      quiet_cycles = (out_valid || req_taken) ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog: give up when nothing moves for too long.
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("[%0t] no request or result for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("tb_packet_ring_fifo_with_headers_top: done, errors");
    $finish;
  end

  task automatic push_req(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                          input logic first, input logic [LEN_W-1:0] len,
                          input logic [RSSI_W-1:0] rssi);
    ring_req_t r;
    r.mode = mode;
    r.data_byte = data;
    r.rx_first = first;
    r.rx_length = len;
    r.rx_rssi = rssi;
    pending_items.push_back(r);
  endtask

  // A request without receive data; the unused fields carry random values.
  task automatic push_cmd(input logic [MODE_W-1:0] mode);
    push_req(mode, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom), RSSI_W'($urandom));
  endtask

  // A received packet of len bytes, of which only the first sent are delivered.
  task automatic push_packet(input int len, input bit addr_hit, input int sent);
    logic [BYTE_W-1:0] b0;
    b0 = (filter_on_m && addr_hit) ? node_addr_m : BYTE_W'($urandom);
    push_req(MODE_RX, b0, 1'b1, LEN_W'(len), RSSI_W'($urandom));
    for (int i = 1; i < sent; i++)
      push_req(MODE_RX, BYTE_W'($urandom), 1'b0, LEN_W'($urandom), RSSI_W'($urandom));
  endtask

  // Mostly whole packets and read bursts, with some noise and broken packets.
  task automatic push_random_traffic(input int target, input int read_pct);
    int made;
    int pick;
    int len;
    int sent;
    int burst;
    made = 0;
    while (made < target) begin
      pick = $urandom_range(99);
      if (pick < read_pct) begin
        burst = $urandom_range(8);
        push_cmd(MODE_NEXT);
        for (int i = 0; i < burst; i++)
          push_cmd(($urandom_range(4) == 0) ? MODE_PEEK : MODE_READ);
        made += burst + 1;
      end else if (pick < read_pct + 8) begin
        push_cmd($urandom_range(1) ? MODE_PEEK : MODE_READ);
        made++;
      end else if (pick < read_pct + 9) begin
        push_cmd(MODE_PURGE);
        made++;
      end else if (pick < read_pct + 11) begin
        push_req(MODE_RX, BYTE_W'($urandom), 1'b0, LEN_W'($urandom), RSSI_W'($urandom));
      end else if (pick < read_pct + 12) begin
        push_cmd(MODE_PURGE + MODE_W'($urandom_range(3, 1)));
      end else if (pick < read_pct + 14) begin
        push_req(MODE_RX, BYTE_W'($urandom), 1'b1, '0, RSSI_W'($urandom));
        made++;
      end else begin
        len = ($urandom_range(15) == 0) ? $urandom_range(255, 1) : $urandom_range(12, 1);
        sent = ($urandom_range(7) == 0) ? $urandom_range(len, 1) : len;
        push_packet(len, 1'($urandom_range(1)), sent);
        made += sent;
      end
    end
  endtask

  // Wait until every request is taken and every result has come back.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || start || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    #1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FILTER) filter_on_m = val[0];
    else if (idx == CFG_NODE_ADDR) node_addr_m = val;
  endtask

  task automatic start_phase(input bit filter, input logic [BYTE_W-1:0] node, input int idle);
    wait_drained();
    write_reg(CFG_FILTER, {7'd0, filter});
    write_reg(CFG_NODE_ADDR, node);
    sender_idle_pct = idle;
    n_phases++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with filtering off: empty ring, stray and zero-length
    // bytes, two kept packets, an abandoned one and reads past the end.
    n_phases++;
    push_cmd(MODE_NEXT);
    push_cmd(MODE_READ);
    push_cmd(MODE_PEEK);
    push_req(MODE_RX, 8'h3C, 1'b0, 8'd9, 16'h0000);
    push_req(MODE_RX, 8'hFF, 1'b1, 8'd0, 16'h7FFF);
    push_req(MODE_RX, 8'h00, 1'b1, 8'd3, 16'h8000);
    push_req(MODE_RX, 8'hFF, 1'b0, 8'hFF, 16'hFFFF);
    push_req(MODE_RX, 8'hA5, 1'b0, 8'd0, 16'h0000);
    push_req(MODE_RX, 8'h11, 1'b1, 8'd5, 16'h1234);
    push_req(MODE_RX, 8'h22, 1'b0, 8'd0, 16'h0000);
    push_req(MODE_RX, 8'h33, 1'b1, 8'd2, 16'h7FFF);
    push_req(MODE_RX, 8'h44, 1'b0, 8'd0, 16'h0000);
    push_cmd(MODE_NEXT);
    push_cmd(MODE_PEEK);
    repeat (4) push_cmd(MODE_READ);
    push_cmd(MODE_NEXT);
    push_cmd(MODE_READ);
    push_cmd(MODE_NEXT);
    push_cmd({MODE_W{1'b1}});
    push_cmd(MODE_PURGE);

    // Filtering on: a matching address alone, then a broadcast packet.
    start_phase(1'b1, 8'hA5, 0);
    push_req(MODE_RX, 8'hA5, 1'b1, 8'd1, 16'h00FF);
    push_req(MODE_RX, 8'h5A, 1'b1, 8'd3, 16'hFF00);
    push_req(MODE_RX, 8'h01, 1'b0, 8'd0, 16'h0000);
    push_req(MODE_RX, 8'h02, 1'b0, 8'd0, 16'h0000);
    push_cmd(MODE_NEXT);
    push_cmd(MODE_NEXT);
    push_cmd(MODE_READ);
    push_cmd(MODE_PURGE);
    // Filtering switched off while a packet is half received.
    push_req(MODE_RX, 8'hA5, 1'b1, 8'd3, 16'h4321);
    wait_drained();
    write_reg(CFG_FILTER, 8'd0);
    push_req(MODE_RX, 8'h77, 1'b0, 8'd0, 16'h0000);
    push_req(MODE_RX, 8'h88, 1'b0, 8'd0, 16'h0000);
    push_cmd(MODE_NEXT);
    push_cmd(MODE_READ);
    push_cmd(MODE_READ);

    // Random phases with different settings and sender idling.
    start_phase(1'b0, 8'h00, 0);
    push_random_traffic(200, 30);
    start_phase(1'b1, 8'hFF, 73);
    push_random_traffic(200, 30);
    start_phase(1'b1, 8'h00, 0);
    push_random_traffic(200, 8);
    start_phase(1'b0, BYTE_W'($urandom), 9);
    push_random_traffic(200, 30);
    start_phase(1'b1, BYTE_W'($urandom), 73);
    push_random_traffic(100, 25);
    // The sender stops until the block has answered everything.
    wait_drained();
    push_random_traffic(100, 25);
    start_phase(1'b0, 8'hFF, 0);
    push_random_traffic(200, 30);

    wait_drained();
    if (expected_results.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("Ran %0d requests in %0d phases, %0d results checked, %0d failures.",
             n_accepted, n_phases, n_checked, error_count);
    $display("Ring saw %0d packets committed, %0d popped and %0d refused or stray-zero bytes.",
             n_commits, n_pops, n_dropped);
    if (error_count == 0) begin
      $display("tb_packet_ring_fifo_with_headers_top: done, clean");
    end else begin
      $display("tb_packet_ring_fifo_with_headers_top: done, errors");
    end
    $finish;
  end

endmodule
